// ----- rtl/sensor_beacon_record_parser_defines.svh -----
// Assertion macros shared by the beacon record parser RTL
`ifndef SENSOR_BEACON_RECORD_PARSER_DEFINES_SVH
`define SENSOR_BEACON_RECORD_PARSER_DEFINES_SVH

// condition implies consequence in the same cycle
`define SBRP_ASSERT_IMPL(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("sbrp assertion failed");

// condition implies consequence in the next cycle
`define SBRP_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("sbrp assertion failed");

`endif

// ----- rtl/sbrp_pkg.sv -----
// Types and constants of the beacon record parser
package sbrp_pkg;

  localparam int unsigned MAX_MSG_BYTES_DEF = 64;
  localparam int unsigned FIFO_DEPTH        = 4;

  localparam logic [15:0] PRODUCT_ID_RESET = 16'h0098;

  localparam logic [7:0] FLAG_ENCRYPTED  = 8'h08;
  localparam logic [7:0] FLAG_CAPABILITY = 8'h20;
  localparam logic [7:0] FLAG_DATA       = 8'h40;

  localparam logic [7:0] FIXED_A = 8'h10;
  localparam logic [7:0] FIXED_B = 8'h00;

  localparam logic [7:0] T_MOTION   = 8'h03;
  localparam logic [7:0] T_TEMP     = 8'h04;
  localparam logic [7:0] T_HUM      = 8'h06;
  localparam logic [7:0] T_LUX      = 8'h07;
  localparam logic [7:0] T_MOIST    = 8'h08;
  localparam logic [7:0] T_COND     = 8'h09;
  localparam logic [7:0] T_BATT     = 8'h0A;
  localparam logic [7:0] T_TEMP_HUM = 8'h0D;
  localparam logic [7:0] T_LUX_MOT  = 8'h0F;
  localparam logic [7:0] T_HCHO     = 8'h10;
  localparam logic [7:0] T_ONOFF    = 8'h12;
  localparam logic [7:0] T_TABLET   = 8'h13;
  localparam logic [7:0] T_IDLE     = 8'h17;

  localparam logic [31:0] LUX_MARK = 32'd100;

  typedef enum logic [2:0] {
    ST_OK,
    ST_ENCRYPTED,
    ST_NO_DATA,
    ST_DUPLICATE,
    ST_WRONG_DEVICE,
    ST_TOO_SHORT,
    ST_NOTHING
  } status_t;

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_FIXED,
    PH_LENGTH,
    PH_VALUE
  } phase_t;

  typedef enum logic [3:0] {
    Q_MOTION,
    Q_TEMP,
    Q_HUM,
    Q_LUX,
    Q_LUX_MOTION,
    Q_MOIST,
    Q_COND,
    Q_BATT,
    Q_TEMP_HUM,
    Q_HCHO,
    Q_ONOFF,
    Q_TABLET,
    Q_IDLE
  } quantity_t;

  typedef enum logic {
    K_RECORD,
    K_STATUS
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    quantity_t          quantity;
    logic signed [32:0] value_a;
    logic signed [15:0] value_b;
    logic               motion_flag;
    logic               light_flag;
    status_t            status;
    logic               capability;
    logic               last;
  } rec_t;

endpackage

// ----- rtl/sbrp_msg_if.sv -----
// Message byte channel: valid/ready with one byte and an end mark
interface sbrp_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       end_of_msg;

  modport source (output valid, output msg_byte, output end_of_msg, input ready);
  modport sink (input valid, input msg_byte, input end_of_msg, output ready);
endinterface

// ----- rtl/sbrp_rec_if.sv -----
// Result channel: valid/ready with one decoded record or status
interface sbrp_rec_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [3:0]         quantity;
  logic signed [32:0] value_a;
  logic signed [15:0] value_b;
  logic               motion_flag;
  logic               light_flag;
  logic [2:0]         status;
  logic               capability;
  logic               last;

  modport source (
    output valid, output kind, output quantity, output value_a, output value_b,
    output motion_flag, output light_flag, output status, output capability,
    output last, input ready
  );
  modport sink (
    input valid, input kind, input quantity, input value_a, input value_b,
    input motion_flag, input light_flag, input status, input capability,
    input last, output ready
  );
endinterface

// ----- rtl/sensor_beacon_record_parser.sv -----
// Beacon service-data record parser: byte-wise header check and record split
//
//   channel | dir | transaction
//   --------+-----+------------------------------------------------------
//   msg     | in  | one message byte, end_of_msg on the final byte
//   rec     | out | one decoded record or the closing status of a message
//   cfg     | in  | cfg_we/cfg_wdata write of expected_product_id
//
// One byte is taken per ready cycle; header checks and record assembly are done in
// the accepting cycle and results land in a 4-entry result queue.
// A byte makes at most two results; msg.ready holds while 2 queue slots are free.
// Results leave one per ready cycle; a stalled rec side fills the queue, then stalls msg.
// rst is synchronous: clears message state, frame counter and queue, loads id 152.
`include "sensor_beacon_record_parser_defines.svh"

module sensor_beacon_record_parser
  import sbrp_pkg::*;
#(
  parameter int unsigned MAX_MSG_BYTES = MAX_MSG_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  sbrp_msg_if.sink    msg,
  sbrp_rec_if.source  rec
);

  localparam int unsigned POS_W = $clog2(MAX_MSG_BYTES + 1);
  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [15:0]       expected_product_id;
  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [7:0]        frame_flags, frame_flags_next;
  logic [7:0]        product_low, product_low_next;
  logic [7:0]        prior_frame_counter, prior_frame_counter_next;
  status_t           early_error, early_error_next;
  phase_t            record_phase, record_phase_next;
  logic [7:0]        record_type, record_type_next;
  logic [2:0]        record_length, record_length_next;
  logic [31:0]       value_bytes, value_bytes_next;
  logic [2:0]        value_count, value_count_next;
  logic              parsing_stopped, parsing_stopped_next;
  logic              any_decoded, any_decoded_next;

  logic              msg_fire, rec_fire;
  logic [POS_W-1:0]  pos_limit, offset, len_min;
  logic              rec_done, rec_hit, rec_push;
  logic [2:0]        value_count_inc;
  rec_t              dec, st_rec;
  status_t           st;

  rec_t              fifo [FIFO_DEPTH];
  logic [PTR_W-1:0]  rd_ptr, wr_ptr;
  logic [CNT_W-1:0]  count, count_next;
  rec_t              rd_data;

  assign pos_limit = POS_W'(MAX_MSG_BYTES);
  assign msg_fire  = msg.valid & msg.ready;
  assign rec_fire  = rec.valid & rec.ready;
  assign msg.ready = count <= CNT_W'(FIFO_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_product_id <= PRODUCT_ID_RESET;
    end else if (cfg_we) begin
      expected_product_id <= cfg_wdata;
    end
  end

  // per-byte header and record state
  always_comb begin
    byte_position_next       = byte_position;
    frame_flags_next         = frame_flags;
    product_low_next         = product_low;
    prior_frame_counter_next = prior_frame_counter;
    early_error_next         = early_error;
    record_phase_next        = record_phase;
    record_type_next         = record_type;
    record_length_next       = record_length;
    value_bytes_next         = value_bytes;
    value_count_next         = value_count;
    parsing_stopped_next     = parsing_stopped;
    value_count_inc          = value_count + 3'd1;
    rec_done                 = 1'b0;
    offset = ((frame_flags & FLAG_CAPABILITY) != 8'h00) ? POS_W'(12) : POS_W'(11);

    if (byte_position < pos_limit) begin
      if (byte_position == POS_W'(0)) begin
        frame_flags_next = msg.msg_byte;
        if ((msg.msg_byte & FLAG_ENCRYPTED) != 8'h00) begin
          early_error_next = ST_ENCRYPTED;
        end else if ((msg.msg_byte & FLAG_DATA) == 8'h00) begin
          early_error_next = ST_NO_DATA;
        end
      end else if (byte_position == POS_W'(2)) begin
        product_low_next = msg.msg_byte;
      end else if (byte_position == POS_W'(3)) begin
        if (early_error == ST_OK && {msg.msg_byte, product_low} != expected_product_id) begin
          early_error_next = ST_WRONG_DEVICE;
        end
      end else if (byte_position == POS_W'(4)) begin
        if (early_error == ST_OK || early_error == ST_WRONG_DEVICE) begin
          if (msg.msg_byte == prior_frame_counter) begin
            early_error_next = ST_DUPLICATE;
          end else begin
            prior_frame_counter_next = msg.msg_byte;
          end
        end
      end else if (byte_position >= offset && early_error == ST_OK && !parsing_stopped) begin
        case (record_phase)
          PH_TYPE: begin
            record_type_next  = msg.msg_byte;
            record_phase_next = PH_FIXED;
          end
          PH_FIXED: begin
            if (msg.msg_byte != FIXED_A && msg.msg_byte != FIXED_B) begin
              parsing_stopped_next = 1'b1;
            end else begin
              record_phase_next = PH_LENGTH;
            end
          end
          PH_LENGTH: begin
            if (msg.msg_byte < 8'd1 || msg.msg_byte > 8'd4) begin
              parsing_stopped_next = 1'b1;
            end else begin
              record_length_next = msg.msg_byte[2:0];
              value_bytes_next   = '0;
              value_count_next   = '0;
              record_phase_next  = PH_VALUE;
            end
          end
          PH_VALUE: begin
            value_bytes_next = value_bytes | (32'(msg.msg_byte) << {value_count[1:0], 3'b000});
            value_count_next = value_count_inc;
            if (value_count_inc >= record_length) begin
              rec_done          = 1'b1;
              record_phase_next = PH_TYPE;
            end
          end
          default: record_phase_next = PH_TYPE;
        endcase
      end
      byte_position_next = byte_position + POS_W'(1);
    end
  end

  // record decode from the assembled value
  always_comb begin
    dec.kind           = K_RECORD;
    dec.quantity       = Q_MOTION;
    dec.value_a        = {1'b0, value_bytes_next};
    dec.value_b        = '0;
    dec.motion_flag    = 1'b0;
    dec.light_flag     = 1'b0;
    dec.status         = ST_OK;
    dec.capability     = frame_flags_next[5];
    dec.last           = 1'b0;
    rec_hit            = 1'b0;
    case (record_type)
      T_MOTION: begin
        rec_hit         = record_length == 3'd1;
        dec.quantity    = Q_MOTION;
        dec.motion_flag = value_bytes_next != 32'd0;
      end
      T_TEMP: begin
        rec_hit      = record_length == 3'd2;
        dec.quantity = Q_TEMP;
        dec.value_a  = {{17{value_bytes_next[15]}}, value_bytes_next[15:0]};
      end
      T_HUM: begin
        rec_hit      = record_length == 3'd2;
        dec.quantity = Q_HUM;
        dec.value_a  = {{17{value_bytes_next[15]}}, value_bytes_next[15:0]};
      end
      T_LUX: begin
        rec_hit        = record_length == 3'd3;
        dec.quantity   = Q_LUX;
        dec.light_flag = value_bytes_next == LUX_MARK;
      end
      T_LUX_MOT: begin
        rec_hit         = record_length == 3'd3;
        dec.quantity    = Q_LUX_MOTION;
        dec.motion_flag = 1'b1;
        dec.light_flag  = value_bytes_next == LUX_MARK;
      end
      T_MOIST: begin
        rec_hit      = record_length == 3'd1;
        dec.quantity = Q_MOIST;
      end
      T_COND: begin
        rec_hit      = record_length == 3'd2;
        dec.quantity = Q_COND;
      end
      T_BATT: begin
        rec_hit      = record_length == 3'd1;
        dec.quantity = Q_BATT;
      end
      T_TEMP_HUM: begin
        rec_hit      = record_length == 3'd4;
        dec.quantity = Q_TEMP_HUM;
        dec.value_a  = {{17{value_bytes_next[15]}}, value_bytes_next[15:0]};
        dec.value_b  = value_bytes_next[31:16];
      end
      T_HCHO: begin
        rec_hit      = record_length == 3'd2;
        dec.quantity = Q_HCHO;
      end
      T_ONOFF: begin
        rec_hit      = record_length == 3'd1;
        dec.quantity = Q_ONOFF;
      end
      T_TABLET: begin
        rec_hit      = record_length == 3'd1;
        dec.quantity = Q_TABLET;
      end
      T_IDLE: begin
        rec_hit         = record_length == 3'd4;
        dec.quantity    = Q_IDLE;
        dec.motion_flag = value_bytes_next == 32'd0;
      end
      default: rec_hit = 1'b0;
    endcase
  end

  assign rec_push         = rec_done & rec_hit;
  assign any_decoded_next = any_decoded | rec_push;

  // closing status
  always_comb begin
    len_min = frame_flags_next[5] ? POS_W'(16) : POS_W'(15);
    if (early_error_next == ST_ENCRYPTED || early_error_next == ST_NO_DATA) begin
      st = early_error_next;
    end else if (byte_position_next < POS_W'(5)) begin
      st = ST_TOO_SHORT;
    end else if (early_error_next != ST_OK) begin
      st = early_error_next;
    end else if (byte_position_next < len_min) begin
      st = ST_TOO_SHORT;
    end else if (any_decoded_next) begin
      st = ST_OK;
    end else begin
      st = ST_NOTHING;
    end
    st_rec.kind           = K_STATUS;
    st_rec.quantity       = Q_MOTION;
    st_rec.value_a        = '0;
    st_rec.value_b        = '0;
    st_rec.motion_flag    = 1'b0;
    st_rec.light_flag     = 1'b0;
    st_rec.status         = st;
    st_rec.capability     = frame_flags_next[5];
    st_rec.last           = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position       <= '0;
      frame_flags         <= '0;
      product_low         <= '0;
      prior_frame_counter <= '0;
      early_error         <= ST_OK;
      record_phase        <= PH_TYPE;
      record_type         <= '0;
      record_length       <= '0;
      value_bytes         <= '0;
      value_count         <= '0;
      parsing_stopped     <= 1'b0;
      any_decoded         <= 1'b0;
    end else if (msg_fire) begin
      prior_frame_counter <= prior_frame_counter_next;
      if (msg.end_of_msg) begin
        byte_position   <= '0;
        frame_flags     <= '0;
        product_low     <= '0;
        early_error     <= ST_OK;
        record_phase    <= PH_TYPE;
        record_type     <= '0;
        record_length   <= '0;
        value_bytes     <= '0;
        value_count     <= '0;
        parsing_stopped <= 1'b0;
        any_decoded     <= 1'b0;
      end else begin
        byte_position   <= byte_position_next;
        frame_flags     <= frame_flags_next;
        product_low     <= product_low_next;
        early_error     <= early_error_next;
        record_phase    <= record_phase_next;
        record_type     <= record_type_next;
        record_length   <= record_length_next;
        value_bytes     <= value_bytes_next;
        value_count     <= value_count_next;
        parsing_stopped <= parsing_stopped_next;
        any_decoded     <= any_decoded_next;
      end
    end
  end

  // result queue: record first, then status
  always_ff @(posedge clk) begin
    if (msg_fire) begin
      if (rec_push) begin
        fifo[wr_ptr] <= dec;
        if (msg.end_of_msg) begin
          fifo[wr_ptr + PTR_W'(1)] <= st_rec;
        end
      end else if (msg.end_of_msg) begin
        fifo[wr_ptr] <= st_rec;
      end
    end
  end

  always_comb begin
    count_next = count - CNT_W'(rec_fire);
    if (msg_fire) begin
      count_next = count_next + CNT_W'(rec_push) + CNT_W'(msg.end_of_msg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (rec_fire) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (msg_fire) begin
        wr_ptr <= wr_ptr + PTR_W'(rec_push) + PTR_W'(msg.end_of_msg);
      end
    end
  end

  assign rd_data            = fifo[rd_ptr];
  assign rec.valid          = count != '0;
  assign rec.kind           = rd_data.kind;
  assign rec.quantity       = rd_data.quantity;
  assign rec.value_a        = rd_data.value_a;
  assign rec.value_b        = rd_data.value_b;
  assign rec.motion_flag    = rd_data.motion_flag;
  assign rec.light_flag     = rd_data.light_flag;
  assign rec.status         = rd_data.status;
  assign rec.capability     = rd_data.capability;
  assign rec.last           = rd_data.last;

  `SBRP_ASSERT_IMPL(a_queue_bound, clk, rst, 1'b1, count <= CNT_W'(FIFO_DEPTH))
  `SBRP_ASSERT_IMPL(a_pos_sat, clk, rst, 1'b1, byte_position <= pos_limit)
  `SBRP_ASSERT_NEXT(a_end_clears, clk, rst, msg_fire && msg.end_of_msg, byte_position == '0)
  `SBRP_ASSERT_IMPL(a_stop_clean, clk, rst, parsing_stopped, early_error == ST_OK)

endmodule

// ----- test/tb_sensor_beacon_record_parser.sv -----
// Testbench of the beacon record parser: directed and random messages checked against a predictor
module tb_sensor_beacon_record_parser
  import sbrp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;
  localparam int SUB_BYTES = 105;
  localparam logic [7:0] KNOWN_TYPE [13] = '{
    T_MOTION, T_TEMP, T_HUM, T_LUX, T_LUX_MOT, T_MOIST, T_COND, T_BATT,
    T_TEMP_HUM, T_HCHO, T_ONOFF, T_TABLET, T_IDLE
  };
  localparam int KNOWN_LEN [13] = '{1, 2, 2, 3, 3, 1, 2, 1, 4, 2, 1, 1, 4};

  typedef struct {
    logic [7:0] b;
    logic       e;
    logic       pin;
    status_t    st;
    logic       cap;
  } beacon_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        pin_en;
  rec_t        pin_rec;

  sbrp_msg_if msg_ch();
  sbrp_rec_if rec_ch();

  sensor_beacon_record_parser DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .msg       (msg_ch),
    .rec       (rec_ch)
  );

  // predictor state
  logic [15:0] id_cfg = PRODUCT_ID_RESET;
  logic [6:0]  pos = '0;
  logic [7:0]  flags = '0;
  logic [7:0]  prod_lo = '0;
  logic [7:0]  last_ctr = '0;
  status_t     err = ST_OK;
  phase_t      phase = PH_TYPE;
  logic [7:0]  rtype = '0;
  logic [2:0]  rlen = '0;
  logic [31:0] vbytes = '0;
  logic [2:0]  vcnt = '0;
  logic        halted = 1'b0;
  logic        decoded_any = 1'b0;

  rec_t        pending_results[$];
  beacon_row_t dir_rows[$];

  int send_idle_pct = 0;
  int rcv_idle_pct = 0;
  int stall_req = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int bytes_in = 0;
  int messages_in = 0;
  int records_seen = 0;
  int statuses_seen = 0;
  int id_writes = 0;
  logic [15:0] cur_product_id = PRODUCT_ID_RESET;
  logic [7:0]  sent_counter = '0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic beacon_row_t dir_row(logic [7:0] b, logic e, logic pin, status_t st,
                                          logic cap);
    beacon_row_t r;
    r.b = b;
    r.e = e;
    r.pin = pin;
    r.st = st;
    r.cap = cap;
    return r;
  endfunction

  function automatic string rec_text(rec_t r);
    return $sformatf("kind=%0d qty=%0d a=%0d b=%0d motion=%b light=%b status=%0d cap=%b last=%b",
                     r.kind, r.quantity, r.value_a, r.value_b, r.motion_flag, r.light_flag,
                     r.status, r.capability, r.last);
  endfunction

  task automatic parse_beacon_byte(input logic [7:0] b, input logic e, ref rec_t res[$]);
    int      hdr_end;
    logic    hit;
    rec_t    r;
    status_t st;
    hdr_end = ((flags & FLAG_CAPABILITY) != 0) ? 12 : 11;
    if (pos < MAX_MSG_BYTES_DEF) begin
      if (pos == 0) begin
        flags = b;
        if ((b & FLAG_ENCRYPTED) != 0) err = ST_ENCRYPTED;
        else if ((b & FLAG_DATA) == 0) err = ST_NO_DATA;
      end else if (pos == 2) begin
        prod_lo = b;
      end else if (pos == 3) begin
        if (err == ST_OK && {b, prod_lo} != id_cfg) err = ST_WRONG_DEVICE;
      end else if (pos == 4) begin
        if (err == ST_OK || err == ST_WRONG_DEVICE) begin
          if (b == last_ctr) err = ST_DUPLICATE;
          else last_ctr = b;
        end
      end else if (pos >= hdr_end && err == ST_OK && !halted) begin
        case (phase)
          PH_TYPE: begin
            rtype = b;
            phase = PH_FIXED;
          end
          PH_FIXED: begin
            if (b != FIXED_A && b != FIXED_B) halted = 1'b1;
            else phase = PH_LENGTH;
          end
          PH_LENGTH: begin
            if (b < 1 || b > 4) begin
              halted = 1'b1;
            end else begin
              rlen = b[2:0];
              vbytes = '0;
              vcnt = '0;
              phase = PH_VALUE;
            end
          end
          default: begin
            vbytes = vbytes | (32'(b) << (8 * vcnt[1:0]));
            vcnt++;
            if (vcnt >= rlen) begin
              r = '0;
              r.kind = K_RECORD;
              r.capability = (flags & FLAG_CAPABILITY) != 0;
              r.value_a = {1'b0, vbytes};
              hit = 1'b0;
              case (rtype)
                T_MOTION: begin
                  r.quantity = Q_MOTION;
                  r.motion_flag = vbytes != 0;
                  hit = rlen == 1;
                end
                T_TEMP: begin
                  r.quantity = Q_TEMP;
                  r.value_a = {{17{vbytes[15]}}, vbytes[15:0]};
                  hit = rlen == 2;
                end
                T_HUM: begin
                  r.quantity = Q_HUM;
                  r.value_a = {{17{vbytes[15]}}, vbytes[15:0]};
                  hit = rlen == 2;
                end
                T_LUX: begin
                  r.quantity = Q_LUX;
                  r.light_flag = vbytes == LUX_MARK;
                  hit = rlen == 3;
                end
                T_LUX_MOT: begin
                  r.quantity = Q_LUX_MOTION;
                  r.motion_flag = 1'b1;
                  r.light_flag = vbytes == LUX_MARK;
                  hit = rlen == 3;
                end
                T_MOIST: begin
                  r.quantity = Q_MOIST;
                  hit = rlen == 1;
                end
                T_COND: begin
                  r.quantity = Q_COND;
                  hit = rlen == 2;
                end
                T_BATT: begin
                  r.quantity = Q_BATT;
                  hit = rlen == 1;
                end
                T_TEMP_HUM: begin
                  r.quantity = Q_TEMP_HUM;
                  r.value_a = {{17{vbytes[15]}}, vbytes[15:0]};
                  r.value_b = vbytes[31:16];
                  hit = rlen == 4;
                end
                T_HCHO: begin
                  r.quantity = Q_HCHO;
                  hit = rlen == 2;
                end
                T_ONOFF: begin
                  r.quantity = Q_ONOFF;
                  hit = rlen == 1;
                end
                T_TABLET: begin
                  r.quantity = Q_TABLET;
                  hit = rlen == 1;
                end
                T_IDLE: begin
                  r.quantity = Q_IDLE;
                  r.motion_flag = vbytes == 0;
                  hit = rlen == 4;
                end
                default: hit = 1'b0;
              endcase
              if (hit) begin
                res.push_back(r);
                decoded_any = 1'b1;
              end
              phase = PH_TYPE;
            end
          end
        endcase
      end
      pos = pos + 1;
    end
    if (e) begin
      hdr_end = ((flags & FLAG_CAPABILITY) != 0) ? 12 : 11;
      if (err == ST_ENCRYPTED || err == ST_NO_DATA) st = err;
      else if (pos < 5) st = ST_TOO_SHORT;
      else if (err != ST_OK) st = err;
      else if (pos < hdr_end + 4) st = ST_TOO_SHORT;
      else st = decoded_any ? ST_OK : ST_NOTHING;
      r = '0;
      r.kind = K_STATUS;
      r.status = st;
      r.capability = (flags & FLAG_CAPABILITY) != 0;
      r.last = 1'b1;
      res.push_back(r);
      pos = '0;
      flags = '0;
      prod_lo = '0;
      err = ST_OK;
      phase = PH_TYPE;
      rtype = '0;
      rlen = '0;
      vbytes = '0;
      vcnt = '0;
      halted = 1'b0;
      decoded_any = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    rec_t fresh[$];
    rec_t got;
    rec_t want;
    if (!rst) begin
      if (cfg_we) id_cfg = cfg_wdata;
      if (msg_ch.valid && msg_ch.ready) begin
        fresh.delete();
        parse_beacon_byte(msg_ch.msg_byte, msg_ch.end_of_msg, fresh);
        if (pin_en) pending_results.push_back(pin_rec);
        else foreach (fresh[i]) pending_results.push_back(fresh[i]);
        bytes_in++;
        if (msg_ch.end_of_msg) messages_in++;
      end
      if (rec_ch.valid && rec_ch.ready) begin
        got = {rec_ch.kind, rec_ch.quantity, rec_ch.value_a, rec_ch.value_b, rec_ch.motion_flag,
               rec_ch.light_flag, rec_ch.status, rec_ch.capability, rec_ch.last};
        if (got.kind == K_RECORD) records_seen++;
        else statuses_seen++;
        if (pending_results.size() == 0) begin
          if (mismatches < 10) $display("unexpected result: %s", rec_text(got));
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got.kind !== want.kind || got.quantity !== want.quantity ||
              got.value_a !== want.value_a || got.value_b !== want.value_b ||
              got.motion_flag !== want.motion_flag || got.light_flag !== want.light_flag ||
              got.status !== want.status || got.capability !== want.capability ||
              got.last !== want.last) begin
            if (mismatches < 10) begin
              $display("mismatch after %0d results", records_seen + statuses_seen);
              $display("  expected %s", rec_text(want));
              $display("  actual   %s", rec_text(got));
            end
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((msg_ch.valid && msg_ch.ready) || (rec_ch.valid && rec_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("no transaction for %0d cycles", quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int n;
    rec_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req != 0) begin
        n = stall_req;
        stall_req = 0;
        rec_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        rec_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic e, input logic pin, input rec_t pr);
    while ($urandom_range(99) < send_idle_pct) begin
      msg_ch.valid <= 1'b0;
      @(posedge clk);
    end
    msg_ch.valid <= 1'b1;
    msg_ch.msg_byte <= b;
    msg_ch.end_of_msg <= e;
    pin_en <= pin;
    pin_rec <= pr;
    do @(posedge clk); while (!msg_ch.ready);
  endtask

  task automatic drain();
    msg_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_product_id(input logic [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_product_id = v;
    id_writes++;
  endtask

  initial begin
    logic [7:0]  m[$];
    logic [7:0]  lux_msg[$];
    logic [7:0]  fb;
    logic [7:0]  ctr;
    logic [7:0]  t;
    logic [7:0]  fixed;
    logic [7:0]  len_byte;
    logic [15:0] pid;
    logic [31:0] val;
    rec_t        pr;
    int          sel;
    int          hdr;
    int          len;
    int          k;
    int          target;
    int          sub_bytes;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    msg_ch.valid = 1'b0;
    msg_ch.msg_byte = '0;
    msg_ch.end_of_msg = 1'b0;
    pin_en = 1'b0;
    pin_rec = '0;
    send_idle_pct = 33;
    rcv_idle_pct = 80;

    dir_rows.push_back(dir_row(8'hFF, 1'b1, 1'b1, ST_ENCRYPTED, 1'b1));
    dir_rows.push_back(dir_row(8'h00, 1'b1, 1'b1, ST_NO_DATA, 1'b0));
    dir_rows.push_back(dir_row(8'h48, 1'b1, 1'b1, ST_ENCRYPTED, 1'b0));
    dir_rows.push_back(dir_row(FLAG_DATA, 1'b0, 1'b0, ST_OK, 1'b0));
    dir_rows.push_back(dir_row(8'h00, 1'b1, 1'b1, ST_TOO_SHORT, 1'b0));
    lux_msg = '{FLAG_DATA | FLAG_CAPABILITY, 8'h00, PRODUCT_ID_RESET[7:0],
                PRODUCT_ID_RESET[15:8], 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                8'h00, T_LUX, FIXED_A, 8'h03, 8'h64, 8'h00, 8'h00};
    foreach (lux_msg[i])
      dir_rows.push_back(dir_row(lux_msg[i], i == lux_msg.size() - 1, 1'b0, ST_OK, 1'b0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      pr = '0;
      pr.kind = K_STATUS;
      pr.status = dir_rows[i].st;
      pr.capability = dir_rows[i].cap;
      pr.last = 1'b1;
      send_byte(dir_rows[i].b, dir_rows[i].e, dir_rows[i].pin, pr);
    end
    sent_counter = 8'h01;

    for (int s = 0; s < 6; s++) begin
      if (s == 2) begin
        send_idle_pct = 80;
        rcv_idle_pct = 33;
      end
      if (s == 4) begin
        send_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      case (s)
        1: set_product_id(16'h0000);
        2: set_product_id(16'hFFFF);
        3, 4: set_product_id(16'($urandom_range(16'hFFFF)));
        5: set_product_id(PRODUCT_ID_RESET);
        default: ;
      endcase
      if (s == 0 || s == 4) stall_req = HOLD_CYCLES;
      sub_bytes = 0;
      while (sub_bytes < SUB_BYTES) begin
        m.delete();
        sel = $urandom_range(99);
        if (sel < 6) begin
          repeat ($urandom_range(1, 6)) m.push_back(8'($urandom_range(255)));
        end else begin
          fb = 8'($urandom_range(255));
          if (sel >= 10) fb = (fb | FLAG_DATA) & ~FLAG_ENCRYPTED;
          m.push_back(fb);
          m.push_back(8'($urandom_range(255)));
          pid = ($urandom_range(9) == 0) ? 16'($urandom_range(16'hFFFF)) : cur_product_id;
          m.push_back(pid[7:0]);
          m.push_back(pid[15:8]);
          if ($urandom_range(9) == 0) begin
            ctr = sent_counter;
          end else begin
            ctr = 8'($urandom_range(255));
            if (ctr == sent_counter) ctr = ctr + 1;
          end
          m.push_back(ctr);
          hdr = ((fb & FLAG_CAPABILITY) != 0) ? 12 : 11;
          while (m.size() < hdr) m.push_back(8'($urandom_range(255)));
          repeat ($urandom_range(0, 4)) begin
            k = $urandom_range(12);
            t = KNOWN_TYPE[k];
            len = KNOWN_LEN[k];
            if ($urandom_range(9) == 0) t = 8'($urandom_range(255));
            if ($urandom_range(14) == 0) len = $urandom_range(1, 4);
            fixed = $urandom_range(1) ? FIXED_A : FIXED_B;
            if ($urandom_range(19) == 0) fixed = 8'($urandom_range(255));
            len_byte = 8'(len);
            if ($urandom_range(24) == 0)
              len_byte = $urandom_range(1) ? 8'h00 : 8'($urandom_range(5, 255));
            case ($urandom_range(3))
              0: val = $urandom();
              1: val = '0;
              2: val = LUX_MARK;
              default: val = 32'hFFFF_FFFF;
            endcase
            m.push_back(t);
            m.push_back(fixed);
            m.push_back(len_byte);
            for (int j = 0; j < len; j++) m.push_back(val[8*j +: 8]);
          end
          case ($urandom_range(19))
            0: repeat ($urandom_range(1, 3)) if (m.size() > hdr) void'(m.pop_back());
            1: begin
              target = MAX_MSG_BYTES_DEF + $urandom_range(0, 8);
              while (m.size() < target) m.push_back(8'($urandom_range(255)));
            end
            2: begin
              target = hdr + $urandom_range(0, 3);
              while (m.size() > target) void'(m.pop_back());
            end
            default: ;
          endcase
        end
        if (m.size() >= 5 && (m[0] & FLAG_DATA) != 0 && (m[0] & FLAG_ENCRYPTED) == 0)
          sent_counter = m[4];
        foreach (m[i]) send_byte(m[i], i == m.size() - 1, 1'b0, '0);
        sub_bytes += m.size();
      end
    end

    drain();
    $display("Covered %0d bytes in %0d messages under %0d product-id settings, with all idle",
             bytes_in, messages_in, id_writes + 1);
    $display("mixes and long output stalls; %0d records and %0d statuses seen, %0d mismatches.",
             records_seen, statuses_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sensor_beacon_record_parser.f -----
+incdir+rtl
rtl/sbrp_pkg.sv
rtl/sbrp_msg_if.sv
rtl/sbrp_rec_if.sv
rtl/sensor_beacon_record_parser.sv
test/tb_sensor_beacon_record_parser.sv
